### src/lcc_pkg.sv
// Shared constants and types for the loop coplanarity check unit.
package lcc_pkg;

    localparam int ID_W       = 16;
    localparam int IN_CW      = 32;
    localparam int COORD_BITS = 32;
    localparam int MAX_POINTS = 64;
    localparam int TOL_W      = 16;
    localparam int PC_W       = 7;
    localparam int MIN_POINTS = 4;
    localparam int TOL_RESET  = 1;

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int NW   = 2 * DW + 1;
    localparam int N2W  = 2 * NW;
    localparam int PW   = NW + DW + 2;
    localparam int OPW  = N2W + 1;
    localparam int LIMW = 2 * TOL_W + N2W + 1;
    localparam int ACCW = (2 * PW > LIMW) ? 2 * PW : LIMW;
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int MW   = ID_W + 3 * CW;

    typedef struct packed {
        logic go;
        logic clr;
        logic sub;
    } t_mac_req;

endpackage

### src/lcc_mac.sv
// Shared shift-add signed multiply-accumulate unit, one operand bit per cycle.
module lcc_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lcc_pkg::t_mac_req                  i_req,
    input  logic signed [lcc_pkg::OPW-1:0]     i_op_a,
    input  logic signed [lcc_pkg::OPW-1:0]     i_op_b,
    output logic                               o_done,
    output logic signed [lcc_pkg::ACCW-1:0]    o_acc
);
    import lcc_pkg::*;

    logic                   r_run;
    logic [ACCW-1:0]        r_a;
    logic [OPW-1:0]         r_b;
    logic                   r_neg;
    logic signed [ACCW-1:0] r_acc;
    logic [OPW-1:0]         mag_a;
    logic [OPW-1:0]         mag_b;
    logic [ACCW-1:0]        addend;

    assign mag_a  = i_op_a[OPW-1] ? OPW'(-i_op_a) : OPW'(i_op_a);
    assign mag_b  = i_op_b[OPW-1] ? OPW'(-i_op_b) : OPW'(i_op_b);
    assign addend = r_neg ? (~r_a + ACCW'(1)) : r_a;
    assign o_done = r_run && (r_b == '0);
    assign o_acc  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_req.go) begin
            r_run <= 1'b1;
        end else if (o_done) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_a   <= ACCW'(mag_a);
            r_b   <= mag_b;
            r_neg <= i_op_a[OPW-1] ^ i_op_b[OPW-1] ^ i_req.sub;
            if (i_req.clr) begin
                r_acc <= '0;
            end
        end else if (r_run && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + $signed(addend);
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

endmodule

### src/loop_coplanarity_check_unit.sv
// Top level: point collection, point store and verdict sequencer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | start / busy       | i_vertex_id, i_pos_x/y/z, i_last_ref
//  result   | o_valid (1 cycle)  | o_non_planar, o_point_count, o_overflow
//  config   | i_cfg_we           | i_cfg_wdata (tolerance)
//
// Each accepted id other than zero is compared with the stored ids, one store read each; a
// duplicate, or a new id that finds the store full, is dropped. On the last reference the
// verdict walks the store up to three times, using the shared multiplier for three, nine and
// four products per point on the three walks. busy stays high until the verdict is out.
// Reset is synchronous; the point store is not cleared. Results cannot be stalled.
module loop_coplanarity_check_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [lcc_pkg::TOL_W-1:0]         i_cfg_wdata,
    input  logic [lcc_pkg::ID_W-1:0]          i_vertex_id,
    input  logic signed [lcc_pkg::IN_CW-1:0]  i_pos_x,
    input  logic signed [lcc_pkg::IN_CW-1:0]  i_pos_y,
    input  logic signed [lcc_pkg::IN_CW-1:0]  i_pos_z,
    input  logic                              i_last_ref,
    output logic                              o_valid,
    output logic                              o_non_planar,
    output logic [lcc_pkg::PC_W-1:0]          o_point_count,
    output logic                              o_overflow
);
    import lcc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_INSERT, S_CHECK, S_RD0, S_P0,
        S_PT_RD, S_PT_D, S_MAC, S_WAIT
    } t_state;

    typedef enum logic [2:0] {
        PH_TOL, PH_D2, PH_CROSS, PH_N2, PH_LIM, PH_DOT, PH_P2
    } t_phase;

    typedef enum logic [1:0] {
        PS_SPAN, PS_NORMAL, PS_PLANE
    } t_pass;

    t_state r_state;
    t_phase r_phase;
    t_pass  r_pass;
    logic [2:0] r_step;

    logic [TOL_W-1:0]     r_tol;
    logic [CNTW-1:0]      r_cnt;
    logic                 r_ovf;
    logic [IW-1:0]        r_idx;

    logic [ID_W-1:0]      r_id;
    logic signed [CW-1:0] r_pos [3];
    logic                 r_last;

    logic [MW-1:0]        mem [MAX_POINTS];
    logic [MW-1:0]        r_rd;

    logic signed [CW-1:0] r_p0 [3];
    logic signed [DW-1:0] r_d [3];
    logic signed [DW-1:0] r_v1 [3];
    logic signed [NW-1:0] r_c [3];
    logic signed [PW-1:0] r_p;
    logic [2*TOL_W-1:0]   r_tol2;
    logic [N2W-1:0]       r_nn;
    logic [ACCW-1:0]      r_lim;

    logic                 r_valid;
    logic                 r_np;
    logic [PC_W-1:0]      r_pc;
    logic                 r_ovf_o;

    t_mac_req               mac_req;
    logic signed [OPW-1:0]  op_a;
    logic signed [OPW-1:0]  op_b;
    logic                   mac_done;
    logic signed [ACCW-1:0] acc;

    logic signed [CW-1:0] rd_c [3];
    logic signed [DW-1:0] d_new [3];
    logic [1:0]           k;
    logic [2:0]           last_step;
    logic                 last_pt;
    logic                 gt_tol;
    logic                 gt_lim;
    logic                 id_hit;

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_non_planar  = r_np;
    assign o_point_count = r_pc;
    assign o_overflow    = r_ovf_o;

    assign rd_c[0] = r_rd[3*CW-1:2*CW];
    assign rd_c[1] = r_rd[2*CW-1:CW];
    assign rd_c[2] = r_rd[CW-1:0];
    assign id_hit  = (r_rd[MW-1:3*CW] == r_id);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            d_new[j] = DW'(rd_c[j]) - DW'(r_p0[j]);
        end
    end

    assign k       = r_step[1:0];
    assign last_pt = ((CNTW'(r_idx) + CNTW'(1)) == r_cnt);
    assign gt_tol  = ($unsigned(acc) > ACCW'(r_tol2));
    assign gt_lim  = ($unsigned(acc) > r_lim);

    always_comb begin
        unique case (r_phase)
            PH_CROSS: last_step = 3'd5;
            PH_D2, PH_N2, PH_DOT: last_step = 3'd2;
            default: last_step = 3'd0;
        endcase
    end

    always_comb begin
        mac_req.go  = (r_state == S_MAC);
        mac_req.clr = (r_step == 3'd0);
        mac_req.sub = 1'b0;
        op_a        = OPW'(r_tol);
        op_b        = OPW'(r_tol);
        unique case (r_phase)
            PH_TOL: begin
                op_a = OPW'(r_tol);
                op_b = OPW'(r_tol);
            end
            PH_D2: begin
                op_a = OPW'(r_d[k]);
                op_b = OPW'(r_d[k]);
            end
            PH_CROSS: begin
                mac_req.clr = ~r_step[0];
                mac_req.sub = r_step[0];
                unique case (r_step)
                    3'd0: begin op_a = OPW'(r_v1[1]); op_b = OPW'(r_d[2]); end
                    3'd1: begin op_a = OPW'(r_v1[2]); op_b = OPW'(r_d[1]); end
                    3'd2: begin op_a = OPW'(r_v1[2]); op_b = OPW'(r_d[0]); end
                    3'd3: begin op_a = OPW'(r_v1[0]); op_b = OPW'(r_d[2]); end
                    3'd4: begin op_a = OPW'(r_v1[0]); op_b = OPW'(r_d[1]); end
                    default: begin op_a = OPW'(r_v1[1]); op_b = OPW'(r_d[0]); end
                endcase
            end
            PH_N2: begin
                op_a = OPW'(r_c[k]);
                op_b = OPW'(r_c[k]);
            end
            PH_LIM: begin
                op_a = OPW'(r_tol2);
                op_b = OPW'(r_nn);
            end
            PH_DOT: begin
                op_a = OPW'(r_c[k]);
                op_b = OPW'(r_d[k]);
            end
            default: begin
                op_a = OPW'(r_p);
                op_b = OPW'(r_p);
            end
        endcase
    end

    lcc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .o_done  (mac_done),
        .o_acc   (acc)
    );

    // point store
    always_ff @(posedge i_clk) begin
        if (r_state == S_INSERT) begin
            mem[r_cnt[IW-1:0]] <= {r_id, r_pos[0], r_pos[1], r_pos[2]};
        end
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tol   <= TOL_W'(TOL_RESET);
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_id     <= i_vertex_id;
                        r_pos[0] <= CW'(i_pos_x);
                        r_pos[1] <= CW'(i_pos_y);
                        r_pos[2] <= CW'(i_pos_z);
                        r_last   <= i_last_ref;
                        r_idx    <= '0;
                        if (i_vertex_id == '0) begin
                            r_state <= S_CHECK;
                        end else if (r_cnt == '0) begin
                            r_state <= S_INSERT;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CMP;
                S_SCAN_CMP: begin
                    if (id_hit) begin
                        r_state <= S_CHECK;
                    end else if (last_pt) begin
                        if (r_cnt == CNTW'(MAX_POINTS)) begin
                            r_ovf   <= 1'b1;
                            r_state <= S_CHECK;
                        end else begin
                            r_state <= S_INSERT;
                        end
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_INSERT: begin
                    r_cnt   <= r_cnt + CNTW'(1);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_cnt < CNTW'(MIN_POINTS)) begin
                        r_valid <= 1'b1;
                        r_np    <= 1'b0;
                        r_pc    <= PC_W'(r_cnt);
                        r_ovf_o <= r_ovf;
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_phase <= PH_TOL;
                        r_step  <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_RD0: r_state <= S_P0;
                S_P0: begin
                    r_p0    <= rd_c;
                    r_idx   <= IW'(1);
                    r_pass  <= PS_SPAN;
                    r_state <= S_PT_RD;
                end
                S_PT_RD: r_state <= S_PT_D;
                S_PT_D: begin
                    r_d    <= d_new;
                    r_step <= '0;
                    unique case (r_pass)
                        PS_SPAN:   r_phase <= PH_D2;
                        PS_NORMAL: r_phase <= PH_CROSS;
                        default:   r_phase <= PH_DOT;
                    endcase
                    r_state <= S_MAC;
                end
                S_MAC: r_state <= S_WAIT;
                S_WAIT: begin
                    if (mac_done) begin
                        if ((r_phase == PH_CROSS) && r_step[0]) begin
                            r_c[r_step[2:1]] <= NW'(acc);
                        end
                        if (r_step != last_step) begin
                            r_step  <= r_step + 3'd1;
                            r_state <= S_MAC;
                        end else begin
                            r_step <= '0;
                            priority case (1'b1)
                                (r_phase == PH_TOL): begin
                                    r_tol2  <= (2*TOL_W)'(acc);
                                    r_idx   <= '0;
                                    r_state <= S_RD0;
                                end
                                (r_phase == PH_CROSS): begin
                                    r_phase <= PH_N2;
                                    r_state <= S_MAC;
                                end
                                (r_phase == PH_D2) && gt_tol: begin
                                    r_v1    <= r_d;
                                    r_pass  <= PS_NORMAL;
                                    r_idx   <= IW'(1);
                                    r_state <= S_PT_RD;
                                end
                                (r_phase == PH_N2) && gt_tol: begin
                                    r_nn    <= N2W'(acc);
                                    r_phase <= PH_LIM;
                                    r_state <= S_MAC;
                                end
                                (r_phase == PH_LIM): begin
                                    r_lim   <= ACCW'(acc);
                                    r_pass  <= PS_PLANE;
                                    r_idx   <= '0;
                                    r_state <= S_PT_RD;
                                end
                                (r_phase == PH_DOT): begin
                                    r_p     <= PW'(acc);
                                    r_phase <= PH_P2;
                                    r_state <= S_MAC;
                                end
                                ((r_phase == PH_P2) && gt_lim) || last_pt: begin
                                    r_valid <= 1'b1;
                                    r_np    <= (r_phase == PH_P2) && gt_lim;
                                    r_pc    <= PC_W'(r_cnt);
                                    r_ovf_o <= r_ovf;
                                    r_cnt   <= '0;
                                    r_ovf   <= 1'b0;
                                    r_state <= S_IDLE;
                                end
                                default: begin
                                    r_idx   <= r_idx + IW'(1);
                                    r_state <= S_PT_RD;
                                end
                            endcase
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
